[hdl/vbrl_pkg.sv]
// ----------------------------------------------------------------------------
// vbrl_pkg
// shared types, command codes and helpers for the valve bank runtime limiter
// ----------------------------------------------------------------------------
package vbrl_pkg;

    localparam int VBRL_NUM_VALVES = 8;

    localparam logic [5:0]  VBRL_MAX_OPEN_RST  = 6'd2;
    localparam logic [15:0] VBRL_MAX_TICKS_RST = 16'd1800;

    localparam logic [2:0] CMD_ON      = 3'd0;
    localparam logic [2:0] CMD_OFF     = 3'd1;
    localparam logic [2:0] CMD_ALL_OFF = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    localparam logic CFG_MAX_OPEN  = 1'b0;
    localparam logic CFG_MAX_TICKS = 1'b1;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] valve;
    } t_in_item;

    typedef struct packed {
        logic       granted;
        logic [7:0] valve_drive;
        logic [7:0] forced_off;
        logic       queried_open;
        logic [5:0] open_count;
    } t_out_item;

    typedef struct packed {
        logic        fire;
        logic [2:0]  cmd;
        logic        on_ok;
        logic [15:0] max_ticks;
    } t_lane_ctrl;

    typedef struct packed {
        logic open;
        logic open_next;
        logic forced;
    } t_lane_stat;

    function automatic logic [5:0] f_popcount32(input logic [31:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++) begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

endpackage

[hdl/vbrl_lane.sv]
// ----------------------------------------------------------------------------
// vbrl_lane
// one valve: open flag, saturating runtime counter and runtime limit check
// ----------------------------------------------------------------------------
module vbrl_lane
    import vbrl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_ctrl i_ctrl,
    input  logic       i_sel,
    output t_lane_stat o_stat
);

    logic        r_open;
    logic [15:0] r_cnt;
    logic        n_open;
    logic [15:0] n_cnt;
    logic [15:0] w_cnt_inc;
    logic        w_forced;

    assign w_cnt_inc = r_cnt + {15'd0, (r_cnt != 16'hFFFF)};

    always_comb begin
        n_open   = r_open;
        n_cnt    = r_cnt;
        w_forced = 1'b0;
        case (i_ctrl.cmd)
            CMD_ON: begin
                if (i_sel && i_ctrl.on_ok) begin
                    n_open = 1'b1;
                    n_cnt  = '0;
                end
            end
            CMD_OFF: begin
                if (i_sel) begin
                    n_open = 1'b0;
                    n_cnt  = '0;
                end
            end
            CMD_ALL_OFF: begin
                n_open = 1'b0;
                n_cnt  = '0;
            end
            CMD_TICK: begin
                if (r_open) begin
                    n_cnt = w_cnt_inc;
                    if (w_cnt_inc >= i_ctrl.max_ticks) begin
                        n_open   = 1'b0;
                        n_cnt    = '0;
                        w_forced = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.fire) begin
            r_open <= n_open;
            r_cnt  <= n_cnt;
        end
    end

    assign o_stat.open      = r_open;
    assign o_stat.open_next = n_open;
    assign o_stat.forced    = w_forced;

endmodule

[hdl/valve_bank_runtime_limiter.sv]
// ----------------------------------------------------------------------------
// valve_bank_runtime_limiter
// valve bank with an open-count limit and a per-valve runtime limit
// ----------------------------------------------------------------------------
//  channel | signals                           | payload
//  --------+-----------------------------------+---------------------------
//  in      | i_in_valid / o_in_ready           | i_in  (command, valve)
//  out     | o_out_valid / i_out_ready         | o_out (granted, drive, ...)
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_wdata  | limit registers, no wait
//
//  one item per cycle unless the output stalls; an item waits in the input
//  register until it fires, when result and all valves update in parallel
//  reset clears all valves and counters and loads limits 2 and 1800
//  with the result held, the input register still takes one more item
// ----------------------------------------------------------------------------
module valve_bank_runtime_limiter
    import vbrl_pkg::*;
#(
    parameter int NUM_VALVES = VBRL_NUM_VALVES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int PAD_W = (NUM_VALVES > 8) ? NUM_VALVES : 8;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [5:0]  r_max_open;
    logic [15:0] r_max_ticks;
    logic [5:0]  r_open_cnt;
    logic [5:0]  n_open_cnt;

    logic                  w_fire;
    logic                  w_granted;
    logic                  w_in_range;
    logic                  w_sel_open;
    logic [NUM_VALVES-1:0] w_sel;
    logic [NUM_VALVES-1:0] w_open;
    logic [NUM_VALVES-1:0] w_open_next;
    logic [NUM_VALVES-1:0] w_forced;
    logic [PAD_W-1:0]      w_open_pad;
    logic [PAD_W-1:0]      w_forced_pad;
    t_lane_ctrl            w_ctrl;
    t_lane_stat            w_stat [NUM_VALVES];
    t_out_item             n_out;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_open  <= VBRL_MAX_OPEN_RST;
            r_max_ticks <= VBRL_MAX_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_OPEN:  r_max_open  <= i_cfg_wdata[5:0];
                CFG_MAX_TICKS: r_max_ticks <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < NUM_VALVES; g++) begin : g_lane
        assign w_sel[g] = (r_in.valve == 5'(g));

        vbrl_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_sel   (w_sel[g]),
            .o_stat  (w_stat[g])
        );

        assign w_open[g]      = w_stat[g].open;
        assign w_open_next[g] = w_stat[g].open_next;
        assign w_forced[g]    = w_stat[g].forced;
    end

    assign w_in_range = |w_sel;
    assign w_sel_open = |(w_open & w_sel);
    assign w_granted  = !((r_in.command == CMD_ON) && w_in_range && !w_sel_open
                          && (r_open_cnt >= r_max_open));

    assign w_ctrl.fire      = w_fire;
    assign w_ctrl.cmd       = r_in.command;
    assign w_ctrl.on_ok     = w_granted;
    assign w_ctrl.max_ticks = r_max_ticks;

    assign n_open_cnt   = f_popcount32(32'(w_open_next));
    assign w_open_pad   = PAD_W'(w_open_next);
    assign w_forced_pad = PAD_W'(w_forced);

    always_comb begin
        n_out.granted      = w_granted;
        n_out.valve_drive  = w_open_pad[7:0];
        n_out.forced_off   = w_forced_pad[7:0];
        n_out.queried_open = |(w_open_next & w_sel);
        n_out.open_count   = n_open_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_cnt <= '0;
        end else if (w_fire) begin
            r_open_cnt <= n_open_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_cnt_tracks_valves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_cnt == f_popcount32(32'(w_open)))
        else $error("open count register out of step with valve flags");

    a_denied_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_granted) |=> $stable(w_open))
        else $error("denied turn-on changed valve state");

    a_forced_are_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.forced_off & o_out.valve_drive) == 8'd0))
        else $error("forced-off valve still driven");

    a_deny_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.granted) |-> (o_out.open_count >= r_max_open))
        else $error("turn-on denied below the open limit");

endmodule
